// ===== rtl/mhpq_pkg.sv =====
// Shared types and constants for the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 8;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [1:0]               status;
        logic [COUNT_OUT_W-1:0]   entry_count;
    } out_t;

    // Operation broadcast to every cell of the sorted row.
    typedef struct packed {
        logic insert_en;
        logic pop_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/max_heap_priority_queue_top.sv =====
// Top level of the priority queue: handshake, entry count and the row of sorted cells.
// Each result is registered and appears on out_data in the cycle after its input transaction.
// Throughput: one item per cycle while out_ready is high; the sorted row of cells updates all
// ranks together, and a new item enters in the same cycle that the waiting result is taken.
// Reset: rst_n clears the entry count and the output valid flag; entry values are not reset.
`default_nettype none

module max_heap_priority_queue_top #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  mhpq_pkg::in_t   in_data,
    output logic            out_valid,
    input  wire             out_ready,
    output mhpq_pkg::out_t  out_data
);
    import mhpq_pkg::*;

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    logic                     accept;
    logic                     is_full;
    logic                     is_empty;
    cell_ctrl_t               ctrl;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;
    logic [COUNT_W+COUNT_OUT_W-1:0] count_ext;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    out_t                     out_reg;
    out_t                     out_next;
    logic signed [DATA_W-1:0] value_w [CAPACITY];
    logic                     gt_w    [CAPACITY];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == COUNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign ctrl.insert_en = accept && (in_data.action == ACT_INSERT) && !is_full;
    assign ctrl.pop_en    = accept && (in_data.action == ACT_POP) && !is_empty;

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert_en)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (ctrl.pop_en)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (accept)
        begin
            out_valid_next       = 1'b1;
            out_next.max_value   = '0;
            out_next.status      = STATUS_OK;
            out_next.entry_count = count_ext[COUNT_OUT_W-1:0];
            if (in_data.action == ACT_POP)
            begin
                if (is_empty)
                begin
                    out_next.status = STATUS_EMPTY;
                end
                else
                begin
                    // The first cell always holds the largest entry.
                    out_next.max_value = value_w[0];
                end
            end
            else if (is_full)
            begin
                out_next.status = STATUS_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     prev_gt;
        logic signed [DATA_W-1:0] prev_value;
        logic signed [DATA_W-1:0] next_value;

        if (i == 0)
        begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_value = '0;
        end
        else
        begin : g_inner
            assign prev_gt    = gt_w[i-1];
            assign prev_value = value_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_value = '0;
        end
        else
        begin : g_more
            assign next_value = value_w[i+1];
        end

        mhpq_cell #(
            .COUNT_W (COUNT_W),
            .INDEX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .ins_value  (in_data.value),
            .prev_gt    (prev_gt),
            .prev_value (prev_value),
            .next_value (next_value),
            .value      (value_w[i]),
            .gt         (gt_w[i])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/mhpq_cell.sv =====
// One cell of the sorted row: holds the entry of a given rank and trades with its neighbors.
`default_nettype none

module mhpq_cell #(
    parameter int COUNT_W = 8,
    parameter int INDEX   = 0
) (
    input  wire                                   clk,
    input  mhpq_pkg::cell_ctrl_t                  ctrl,
    input  wire [COUNT_W-1:0]                     count,
    input  wire signed [mhpq_pkg::DATA_W-1:0]     ins_value,
    input  wire                                   prev_gt,
    input  wire signed [mhpq_pkg::DATA_W-1:0]     prev_value,
    input  wire signed [mhpq_pkg::DATA_W-1:0]     next_value,
    output logic signed [mhpq_pkg::DATA_W-1:0]    value,
    output logic                                  gt
);
    import mhpq_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occupied;

    assign occupied = (count > COUNT_W'(INDEX));

    // The new value goes in front of this entry when it is strictly larger
    // or when this rank is still empty. Along the row gt is monotone.
    assign gt = !occupied || (ins_value > value_reg);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (prev_gt)
            begin
                value_next = prev_value;
            end
            else if (gt)
            begin
                value_next = ins_value;
            end
        end
        else if (ctrl.pop_en)
        begin
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire
